>>> hdl/audio_mix_ring_buffer_defines.svh
// Assertion macros shared by the audio mixer ring buffer checkers.
`ifndef AUDIO_MIX_RING_BUFFER_DEFINES_SVH
`define AUDIO_MIX_RING_BUFFER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and disabled during reset.
`define AMRB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("audio mixer ring buffer check failed");

// Next-cycle implication, sampled on i_clk and disabled during reset.
`define AMRB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("audio mixer ring buffer check failed");

`endif

>>> hdl/amrb_pkg.sv
// Package with the constants, types and arithmetic helpers of the audio mixer ring buffer.
package amrb_pkg;

    localparam int RING_DEPTH = 8192;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int LVL_W      = $clog2(RING_DEPTH + 1);
    localparam int FILL_W     = 14;
    localparam int SAMPLE_W   = 16;
    localparam int CNT_W      = 32;
    localparam int GAIN_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PULL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FM_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOUND_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_GAIN     = 2'd2;

    localparam logic              FM_ENABLE_RST    = 1'b1;
    localparam logic              SOUND_ENABLE_RST = 1'b1;
    localparam logic [GAIN_W-1:0] MIX_GAIN_RST     = 8'd16;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;
    localparam logic [SAMPLE_W-1:0]        NZ_MAX     = 16'hFFFF;

    // Statistics of the ring as they stand after one item.
    typedef struct packed {
        logic              hit;
        logic [FILL_W-1:0] fill_level;
        logic [FILL_W-1:0] fill_peak;
        logic [CNT_W-1:0]  dropped;
        logic [CNT_W-1:0]  underrun;
        logic [CNT_W-1:0]  short_req;
    } t_ring_snap;

    // Halves a 17-bit sum, truncating toward zero.
    function automatic logic signed [SAMPLE_W-1:0] f_half_trunc(logic signed [SAMPLE_W:0] s);
        logic signed [SAMPLE_W:0] t;
        t = s + $signed({{SAMPLE_W{1'b0}}, s[SAMPLE_W]});
        return t[SAMPLE_W:1];
    endfunction

    // Saturates a scaled sample to the signed 16-bit range.
    function automatic logic signed [SAMPLE_W-1:0] f_clip16(logic signed [25:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > 26'(SAMPLE_MAX)) begin
            r = SAMPLE_MAX;
        end else if (v < 26'(SAMPLE_MIN)) begin
            r = SAMPLE_MIN;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> hdl/amrb_in_if.sv
// Input channel of the audio mixer ring buffer: valid, ready and one item.
interface amrb_in_if;
    logic                               valid;
    logic                               ready;
    logic                               op;
    logic signed [amrb_pkg::SAMPLE_W-1:0] psg_left;
    logic signed [amrb_pkg::SAMPLE_W-1:0] psg_right;
    logic signed [amrb_pkg::SAMPLE_W-1:0] fm_melody;
    logic signed [amrb_pkg::SAMPLE_W-1:0] fm_rhythm;
    logic                               last_of_batch;

    modport source (output valid, output op, output psg_left, output psg_right,
                    output fm_melody, output fm_rhythm, output last_of_batch,
                    input ready);
    modport sink   (input valid, input op, input psg_left, input psg_right,
                    input fm_melody, input fm_rhythm, input last_of_batch,
                    output ready);
endinterface

>>> hdl/amrb_out_if.sv
// Output channel of the audio mixer ring buffer: valid, ready and one result.
interface amrb_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [amrb_pkg::SAMPLE_W-1:0] out_left;
    logic signed [amrb_pkg::SAMPLE_W-1:0] out_right;
    logic signed [amrb_pkg::SAMPLE_W-1:0] pull_sample;
    logic                                 pull_hit;
    logic [amrb_pkg::FILL_W-1:0]          fill_level;
    logic [amrb_pkg::FILL_W-1:0]          fill_peak;
    logic [amrb_pkg::CNT_W-1:0]           dropped_count;
    logic [amrb_pkg::CNT_W-1:0]           underrun_count;
    logic [amrb_pkg::CNT_W-1:0]           short_request_count;
    logic [amrb_pkg::SAMPLE_W-1:0]        batch_peak;
    logic [amrb_pkg::SAMPLE_W-1:0]        batch_nonzero;

    modport source (output valid, output out_left, output out_right, output pull_sample,
                    output pull_hit, output fill_level, output fill_peak,
                    output dropped_count, output underrun_count,
                    output short_request_count, output batch_peak,
                    output batch_nonzero, input ready);
    modport sink   (input valid, input out_left, input out_right, input pull_sample,
                    input pull_hit, input fill_level, input fill_peak,
                    input dropped_count, input underrun_count,
                    input short_request_count, input batch_peak,
                    input batch_nonzero, output ready);
endinterface

>>> hdl/amrb_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module amrb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/amrb_ring_ctrl.sv
// Ring pointers, fill level and the drop, underrun and short-request counters.
module amrb_ring_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_op,
    input  logic                        i_last,
    input  logic                        i_sound_enable,
    output logic                        o_rd_en,
    output logic [amrb_pkg::PTR_W-1:0]  o_rd_addr,
    output logic [amrb_pkg::PTR_W-1:0]  o_wr_addr,
    output amrb_pkg::t_ring_snap        o_snap
);

    logic [amrb_pkg::PTR_W-1:0] r_rp, n_rp;
    logic [amrb_pkg::PTR_W-1:0] r_wp, n_wp;
    logic [amrb_pkg::LVL_W-1:0] r_level, n_level;
    logic [amrb_pkg::LVL_W-1:0] r_peak, n_peak;
    logic [amrb_pkg::CNT_W-1:0] r_drop, n_drop;
    logic [amrb_pkg::CNT_W-1:0] r_under, n_under;
    logic [amrb_pkg::CNT_W-1:0] r_short, n_short;
    logic                       r_missed, n_missed;
    logic                       hit;
    logic                       full;
    logic [amrb_pkg::PTR_W-1:0] rp_inc;
    logic [amrb_pkg::PTR_W-1:0] wp_inc;
    logic [amrb_pkg::LVL_W+amrb_pkg::FILL_W-1:0] level_ext;
    logic [amrb_pkg::LVL_W+amrb_pkg::FILL_W-1:0] peak_ext;

    assign hit  = (i_op == amrb_pkg::OP_PULL) && i_sound_enable && (r_level != '0);
    assign full = (r_level == amrb_pkg::LVL_W'(amrb_pkg::RING_DEPTH));

    assign rp_inc = (r_rp == amrb_pkg::PTR_W'(amrb_pkg::RING_DEPTH - 1)) ? '0 : r_rp + 1'b1;
    assign wp_inc = (r_wp == amrb_pkg::PTR_W'(amrb_pkg::RING_DEPTH - 1)) ? '0 : r_wp + 1'b1;

    always_comb begin
        n_rp     = r_rp;
        n_wp     = r_wp;
        n_level  = r_level;
        n_peak   = r_peak;
        n_drop   = r_drop;
        n_under  = r_under;
        n_short  = r_short;
        n_missed = r_missed;
        if (i_accept) begin
            if (i_op == amrb_pkg::OP_PUSH) begin
                // A full ring loses its oldest sample to make room.
                if (full) begin
                    n_rp   = rp_inc;
                    n_drop = r_drop + 1'b1;
                end else begin
                    n_level = r_level + 1'b1;
                end
                n_wp = wp_inc;
                if (n_level > r_peak) begin
                    n_peak = n_level;
                end
            end else begin
                if (hit) begin
                    n_rp    = rp_inc;
                    n_level = r_level - 1'b1;
                end else begin
                    n_under = r_under + 1'b1;
                end
                if (i_last) begin
                    if (r_missed || !hit) begin
                        n_short = r_short + 1'b1;
                    end
                    n_missed = 1'b0;
                end else if (!hit) begin
                    n_missed = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp     <= '0;
            r_wp     <= '0;
            r_level  <= '0;
            r_peak   <= '0;
            r_drop   <= '0;
            r_under  <= '0;
            r_short  <= '0;
            r_missed <= 1'b0;
        end else begin
            r_rp     <= n_rp;
            r_wp     <= n_wp;
            r_level  <= n_level;
            r_peak   <= n_peak;
            r_drop   <= n_drop;
            r_under  <= n_under;
            r_short  <= n_short;
            r_missed <= n_missed;
        end
    end

    // The fill figures are reported in 14 bits whatever the ring depth.
    assign level_ext = {{amrb_pkg::FILL_W{1'b0}}, n_level};
    assign peak_ext  = {{amrb_pkg::FILL_W{1'b0}}, n_peak};

    assign o_rd_en   = i_accept && hit;
    assign o_rd_addr = r_rp;
    assign o_wr_addr = r_wp;

    assign o_snap.hit        = hit;
    assign o_snap.fill_level = level_ext[amrb_pkg::FILL_W-1:0];
    assign o_snap.fill_peak  = peak_ext[amrb_pkg::FILL_W-1:0];
    assign o_snap.dropped    = n_drop;
    assign o_snap.underrun   = n_under;
    assign o_snap.short_req  = n_short;

endmodule

>>> hdl/amrb_batch_stats.sv
// Running and latched peak and nonzero statistics of render batches.
module amrb_batch_stats (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_commit,
    input  logic                                 i_is_push,
    input  logic                                 i_last,
    input  logic signed [amrb_pkg::SAMPLE_W-1:0] i_mono,
    output logic [amrb_pkg::SAMPLE_W-1:0]        o_batch_peak,
    output logic [amrb_pkg::SAMPLE_W-1:0]        o_batch_nonzero
);

    logic [amrb_pkg::SAMPLE_W-1:0] r_run_peak, n_run_peak;
    logic [amrb_pkg::SAMPLE_W-1:0] r_run_nz, n_run_nz;
    logic [amrb_pkg::SAMPLE_W-1:0] r_lat_peak, n_lat_peak;
    logic [amrb_pkg::SAMPLE_W-1:0] r_lat_nz, n_lat_nz;
    logic [amrb_pkg::SAMPLE_W-1:0] mag;
    logic [amrb_pkg::SAMPLE_W-1:0] upd_peak;
    logic [amrb_pkg::SAMPLE_W-1:0] upd_nz;

    // The magnitude of the most negative sample still fits as unsigned.
    assign mag = i_mono[amrb_pkg::SAMPLE_W-1] ? amrb_pkg::SAMPLE_W'(-i_mono)
                                              : amrb_pkg::SAMPLE_W'(i_mono);

    assign upd_peak = (mag > r_run_peak) ? mag : r_run_peak;
    assign upd_nz   = ((i_mono != '0) && (r_run_nz != amrb_pkg::NZ_MAX)) ? r_run_nz + 1'b1
                                                                         : r_run_nz;

    always_comb begin
        n_run_peak = r_run_peak;
        n_run_nz   = r_run_nz;
        n_lat_peak = r_lat_peak;
        n_lat_nz   = r_lat_nz;
        if (i_is_push) begin
            if (i_last) begin
                n_lat_peak = upd_peak;
                n_lat_nz   = upd_nz;
                n_run_peak = '0;
                n_run_nz   = '0;
            end else begin
                n_run_peak = upd_peak;
                n_run_nz   = upd_nz;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_peak <= '0;
            r_run_nz   <= '0;
            r_lat_peak <= '0;
            r_lat_nz   <= '0;
        end else if (i_commit) begin
            r_run_peak <= n_run_peak;
            r_run_nz   <= n_run_nz;
            r_lat_peak <= n_lat_peak;
            r_lat_nz   <= n_lat_nz;
        end
    end

    // Values as they stand once the word in the mix stage has been taken.
    assign o_batch_peak    = n_lat_peak;
    assign o_batch_nonzero = n_lat_nz;

endmodule

>>> hdl/audio_mix_ring_buffer.sv
// Top level of the audio mixer with an overwrite-oldest sample ring.
//
// The block takes one word per clock cycle while results are taken, pushes
// (mix and store) and pulls (read the oldest sample) in any order, and passes
// each word through the mix stage and the output register: the ring pointers,
// fill level and counters are updated in the cycle of acceptance while the
// ring read is issued, and the mix stage multiplies by the gain, clips, forms
// the mono sample and writes it into the ring as the word moves on to the
// output register. The ring is one block RAM with a single write port and a
// single registered read port, and that port arrangement together with the
// one multiplier per channel sets the rate of one word a cycle. A pull that
// follows a push directly and reads the entry that push is writing takes the
// sample from a forwarding register instead of the RAM. An output register
// parts the two sides, so a new word is taken while a finished result waits.
// The ring needs no clearing pass after reset, since only entries that have
// been written are ever read. Configuration registers are written through
// i_cfg_we, i_cfg_idx and i_cfg_data; index 0 is the FM enable, 1 the sound
// enable and 2 the mix gain, and a write to any other index is ignored.
module audio_mix_ring_buffer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    amrb_in_if.sink                          i_in,
    amrb_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [amrb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [amrb_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // Configuration registers.
    logic                        r_fm_enable;
    logic                        r_sound_enable;
    logic [amrb_pkg::GAIN_W-1:0] r_mix_gain;

    // Handshake of the two stages.
    logic in_go;
    logic s1_go;

    // Mix stage registers.
    logic                                 r_s1_v;
    logic                                 r_s1_op;
    logic                                 r_s1_last;
    logic signed [amrb_pkg::SAMPLE_W:0]   r_s1_sl;
    logic signed [amrb_pkg::SAMPLE_W:0]   r_s1_sr;
    logic [amrb_pkg::PTR_W-1:0]           r_s1_waddr;
    amrb_pkg::t_ring_snap                 r_s1_snap;
    logic                                 r_s1_fwd;
    logic signed [amrb_pkg::SAMPLE_W-1:0] r_s1_fwd_data;

    // Output register.
    logic                                 r_out_v;
    logic signed [amrb_pkg::SAMPLE_W-1:0] r_out_left;
    logic signed [amrb_pkg::SAMPLE_W-1:0] r_out_right;
    logic signed [amrb_pkg::SAMPLE_W-1:0] r_out_pulled;
    logic                                 r_out_hit;
    logic [amrb_pkg::FILL_W-1:0]          r_out_level;
    logic [amrb_pkg::FILL_W-1:0]          r_out_peak;
    logic [amrb_pkg::CNT_W-1:0]           r_out_drop;
    logic [amrb_pkg::CNT_W-1:0]           r_out_under;
    logic [amrb_pkg::CNT_W-1:0]           r_out_short;
    logic [amrb_pkg::SAMPLE_W-1:0]        r_out_bpeak;
    logic [amrb_pkg::SAMPLE_W-1:0]        r_out_bnz;

    // Ring control and RAM connections.
    logic                          rd_en;
    logic [amrb_pkg::PTR_W-1:0]    rd_addr;
    logic [amrb_pkg::PTR_W-1:0]    wr_addr;
    amrb_pkg::t_ring_snap          snap;
    logic [amrb_pkg::SAMPLE_W-1:0] ram_rd_data;
    logic                          ram_we;

    // Acceptance-cycle arithmetic.
    logic signed [amrb_pkg::SAMPLE_W:0]   fm_sum;
    logic signed [amrb_pkg::SAMPLE_W-1:0] fm_avg;
    logic signed [amrb_pkg::SAMPLE_W:0]   sum_l;
    logic signed [amrb_pkg::SAMPLE_W:0]   sum_r;
    logic                                 fwd_hit;

    // Mix stage arithmetic.
    logic signed [25:0]                   prod_l;
    logic signed [25:0]                   prod_r;
    logic signed [amrb_pkg::SAMPLE_W-1:0] left;
    logic signed [amrb_pkg::SAMPLE_W-1:0] right;
    logic signed [amrb_pkg::SAMPLE_W-1:0] mono;
    logic signed [amrb_pkg::SAMPLE_W-1:0] mix_l;
    logic signed [amrb_pkg::SAMPLE_W-1:0] mix_r;
    logic signed [amrb_pkg::SAMPLE_W-1:0] pulled;
    logic [amrb_pkg::SAMPLE_W-1:0]        batch_peak;
    logic [amrb_pkg::SAMPLE_W-1:0]        batch_nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fm_enable    <= amrb_pkg::FM_ENABLE_RST;
            r_sound_enable <= amrb_pkg::SOUND_ENABLE_RST;
            r_mix_gain     <= amrb_pkg::MIX_GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                amrb_pkg::CFG_FM_ENABLE: begin
                    r_fm_enable <= i_cfg_data[0];
                end
                amrb_pkg::CFG_SOUND_ENABLE: begin
                    r_sound_enable <= i_cfg_data[0];
                end
                amrb_pkg::CFG_MIX_GAIN: begin
                    r_mix_gain <= i_cfg_data[amrb_pkg::GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The mix stage moves on when the output register is free or being emptied,
    // and a new word enters whenever the mix stage will be free.
    assign s1_go      = r_s1_v && (!r_out_v || o_out.ready);
    assign i_in.ready = !r_s1_v || s1_go;
    assign in_go      = i_in.valid && i_in.ready;

    amrb_ring_ctrl u_ring_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_go),
        .i_op           (i_in.op),
        .i_last         (i_in.last_of_batch),
        .i_sound_enable (r_sound_enable),
        .o_rd_en        (rd_en),
        .o_rd_addr      (rd_addr),
        .o_wr_addr      (wr_addr),
        .o_snap         (snap)
    );

    // FM average and the per-side sums before the gain is applied.
    assign fm_sum = {i_in.fm_melody[amrb_pkg::SAMPLE_W-1], i_in.fm_melody}
                  + {i_in.fm_rhythm[amrb_pkg::SAMPLE_W-1], i_in.fm_rhythm};
    assign fm_avg = r_fm_enable ? amrb_pkg::f_half_trunc(fm_sum) : '0;
    assign sum_l  = {fm_avg[amrb_pkg::SAMPLE_W-1], fm_avg}
                  + {i_in.psg_left[amrb_pkg::SAMPLE_W-1], i_in.psg_left};
    assign sum_r  = {fm_avg[amrb_pkg::SAMPLE_W-1], fm_avg}
                  + {i_in.psg_right[amrb_pkg::SAMPLE_W-1], i_in.psg_right};

    // A pull reading the entry that the push in the mix stage writes at this
    // same edge would see the old RAM contents, so the new sample is kept aside.
    assign fwd_hit = rd_en && r_s1_v && (r_s1_op == amrb_pkg::OP_PUSH)
                   && (r_s1_waddr == rd_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (in_go) begin
            r_s1_v <= 1'b1;
        end else if (s1_go) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_s1_op       <= i_in.op;
            r_s1_last     <= i_in.last_of_batch;
            r_s1_sl       <= sum_l;
            r_s1_sr       <= sum_r;
            r_s1_waddr    <= wr_addr;
            r_s1_snap     <= snap;
            r_s1_fwd      <= fwd_hit;
            r_s1_fwd_data <= mono;
        end
    end

    // Gain, clip and mono average of the word in the mix stage.
    assign prod_l = r_s1_sl * $signed({1'b0, r_mix_gain});
    assign prod_r = r_s1_sr * $signed({1'b0, r_mix_gain});
    assign left   = amrb_pkg::f_clip16(prod_l);
    assign right  = amrb_pkg::f_clip16(prod_r);
    assign mono   = amrb_pkg::f_half_trunc({left[amrb_pkg::SAMPLE_W-1], left}
                                         + {right[amrb_pkg::SAMPLE_W-1], right});

    assign ram_we = s1_go && (r_s1_op == amrb_pkg::OP_PUSH);

    amrb_ram #(
        .WIDTH (amrb_pkg::SAMPLE_W),
        .DEPTH (amrb_pkg::RING_DEPTH)
    ) u_ring_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_s1_waddr),
        .i_wr_data (mono),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_rd_data)
    );

    amrb_batch_stats u_batch_stats (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_commit        (s1_go),
        .i_is_push       (r_s1_op == amrb_pkg::OP_PUSH),
        .i_last          (r_s1_last),
        .i_mono          (mono),
        .o_batch_peak    (batch_peak),
        .o_batch_nonzero (batch_nz)
    );

    // Pushes report the mix and no pulled sample; pulls report the reverse.
    assign mix_l  = (r_s1_op == amrb_pkg::OP_PUSH) ? left : '0;
    assign mix_r  = (r_s1_op == amrb_pkg::OP_PUSH) ? right : '0;
    assign pulled = ((r_s1_op == amrb_pkg::OP_PULL) && r_s1_snap.hit)
                  ? (r_s1_fwd ? r_s1_fwd_data : $signed(ram_rd_data)) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s1_go) begin
            r_out_v <= 1'b1;
        end else if (o_out.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_left   <= mix_l;
            r_out_right  <= mix_r;
            r_out_pulled <= pulled;
            r_out_hit    <= (r_s1_op == amrb_pkg::OP_PULL) && r_s1_snap.hit;
            r_out_level  <= r_s1_snap.fill_level;
            r_out_peak   <= r_s1_snap.fill_peak;
            r_out_drop   <= r_s1_snap.dropped;
            r_out_under  <= r_s1_snap.underrun;
            r_out_short  <= r_s1_snap.short_req;
            r_out_bpeak  <= batch_peak;
            r_out_bnz    <= batch_nz;
        end
    end

    assign o_out.valid               = r_out_v;
    assign o_out.out_left            = r_out_left;
    assign o_out.out_right           = r_out_right;
    assign o_out.pull_sample         = r_out_pulled;
    assign o_out.pull_hit            = r_out_hit;
    assign o_out.fill_level          = r_out_level;
    assign o_out.fill_peak           = r_out_peak;
    assign o_out.dropped_count       = r_out_drop;
    assign o_out.underrun_count      = r_out_under;
    assign o_out.short_request_count = r_out_short;
    assign o_out.batch_peak          = r_out_bpeak;
    assign o_out.batch_nonzero       = r_out_bnz;

endmodule

>>> hdl/amrb_checker.sv
// Port-level checker of the audio mixer ring buffer and its bind to the top level.
`include "audio_mix_ring_buffer_defines.svh"

module amrb_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_out_valid,
    input logic                                 i_out_ready,
    input logic signed [amrb_pkg::SAMPLE_W-1:0] i_out_left,
    input logic signed [amrb_pkg::SAMPLE_W-1:0] i_out_right,
    input logic signed [amrb_pkg::SAMPLE_W-1:0] i_pull_sample,
    input logic                                 i_pull_hit,
    input logic [amrb_pkg::FILL_W-1:0]          i_fill_level,
    input logic [amrb_pkg::FILL_W-1:0]          i_fill_peak
);

    // A waiting result is not withdrawn.
    `AMRB_ASSERT_NXT(a_out_held, i_out_valid && !i_out_ready, i_out_valid)

    // A pull that took a sample carries no mix.
    `AMRB_ASSERT_IMP(a_hit_no_mix, i_out_valid && i_pull_hit, i_out_left == '0 && i_out_right == '0)

    // A nonzero pulled sample only comes from a real ring read.
    `AMRB_ASSERT_IMP(a_sample_needs_hit, i_out_valid && i_pull_sample != '0, i_pull_hit)

    // The fill level never exceeds the peak seen so far.
    `AMRB_ASSERT_IMP(a_level_le_peak, i_out_valid, i_fill_level <= i_fill_peak)

endmodule

bind audio_mix_ring_buffer amrb_checker u_amrb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_left    (o_out.out_left),
    .i_out_right   (o_out.out_right),
    .i_pull_sample (o_out.pull_sample),
    .i_pull_hit    (o_out.pull_hit),
    .i_fill_level  (o_out.fill_level),
    .i_fill_peak   (o_out.fill_peak)
);

>>> test/audio_mix_ring_buffer_test.sv
// Self-checking testbench of the audio mixer ring buffer, with its own mixing and ring predictor.
module audio_mix_ring_buffer_test;
    import amrb_pkg::*;

    // Half a period of 10 gives the 20-unit clock period.
    localparam int HALF_PERIOD = 10;
    // Cycles for which the receiver refuses results once, so that the block fills up.
    localparam int LONG_HOLD   = 300;
    // Generous bound on the run: roughly 1200 words, each allowed its longest sender gap
    // and its longest receiver stall, plus the one long hold and the register writes,
    // then taken about five times over.
    localparam int CYCLE_LIMIT = 500_000;
    // Cycles allowed after the last result.
    localparam int SETTLE      = 4;
    // Index that maps to no register; the block must ignore a write to it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // One input word as the sender offers it.
    typedef struct packed {
        logic                       op;
        logic signed [SAMPLE_W-1:0] psg_left;
        logic signed [SAMPLE_W-1:0] psg_right;
        logic signed [SAMPLE_W-1:0] fm_melody;
        logic signed [SAMPLE_W-1:0] fm_rhythm;
        logic                       last_of_batch;
    } mix_item_t;

    // One result word as the block should return it.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_left;
        logic signed [SAMPLE_W-1:0] out_right;
        logic signed [SAMPLE_W-1:0] pull_sample;
        logic                       pull_hit;
        logic [FILL_W-1:0]          fill_level;
        logic [FILL_W-1:0]          fill_peak;
        logic [CNT_W-1:0]           dropped_count;
        logic [CNT_W-1:0]           underrun_count;
        logic [CNT_W-1:0]           short_request_count;
        logic [SAMPLE_W-1:0]        batch_peak;
        logic [SAMPLE_W-1:0]        batch_nonzero;
    } mix_result_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    amrb_in_if  in_ch ();
    amrb_out_if out_ch ();

    audio_mix_ring_buffer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Words waiting to be offered, and results that accepted words are owed.
    mix_item_t   pending_words[$];
    mix_result_t expected_mix[$];
    mix_item_t   on_offer;
    bit          offering;

    // Our own copy of the configuration registers.
    bit fm_on;
    bit sound_on;
    int gain;

    // Our own copy of the ring and its statistics.
    logic signed [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
    int           rd_ptr;
    int           wr_ptr;
    int           level;
    int           level_hi;
    logic [31:0]  drops;
    logic [31:0]  underruns;
    logic [31:0]  shorts;
    bit           missed;
    int           run_peak;
    int           run_nz;
    int           held_peak;
    int           held_nz;

    int  mismatches;
    int  cycle_count;
    int  send_gap;
    int  send_calm;
    int  rcv_stall;
    int  rcv_calm;
    int  hold_count;
    logic hold_request;
    logic long_hold;

    // The clock simply toggles every half period.
    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // Saturates a mixed sample to the signed 16-bit range.
    function automatic int saturate16(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Works out the result of one accepted word and moves the predicted state on. Besides
    // the ring, pushes touch only the batch statistics and pulls only the pull request state.
    function automatic mix_result_t predict_mix(mix_item_t it);
        mix_result_t r;
        int fm;
        int lft;
        int rgt;
        int mono;
        int mag;
        r = '0;
        if (it.op == OP_PUSH) begin
            // The FM average truncates toward zero, as SystemVerilog division does.
            fm = 0;
            if (fm_on) fm = (int'(it.fm_melody) + int'(it.fm_rhythm)) / 2;
            lft  = saturate16((fm + int'(it.psg_left)) * gain);
            rgt  = saturate16((fm + int'(it.psg_right)) * gain);
            mono = (lft + rgt) / 2;
            mag  = (mono < 0) ? -mono : mono;
            if (mag > run_peak) run_peak = mag;
            if (mono != 0 && run_nz < 65535) run_nz++;
            // A full ring gives up its oldest sample before the new one goes in.
            if (level >= RING_DEPTH) begin
                rd_ptr = (rd_ptr + 1) % RING_DEPTH;
                level--;
                drops++;
            end
            ring_mem[wr_ptr] = mono[SAMPLE_W-1:0];
            wr_ptr = (wr_ptr + 1) % RING_DEPTH;
            level++;
            if (level > level_hi) level_hi = level;
            if (it.last_of_batch) begin
                held_peak = run_peak;
                held_nz   = run_nz;
                run_peak  = 0;
                run_nz    = 0;
            end
            r.out_left  = lft[SAMPLE_W-1:0];
            r.out_right = rgt[SAMPLE_W-1:0];
        end else begin
            // With sound disabled the ring is left alone and the pull counts as missed.
            if (sound_on && level != 0) begin
                r.pull_sample = ring_mem[rd_ptr];
                r.pull_hit    = 1'b1;
                rd_ptr = (rd_ptr + 1) % RING_DEPTH;
                level--;
            end else begin
                underruns++;
                missed = 1'b1;
            end
            if (it.last_of_batch) begin
                if (missed) shorts++;
                missed = 1'b0;
            end
        end
        r.fill_level          = level[FILL_W-1:0];
        r.fill_peak           = level_hi[FILL_W-1:0];
        r.dropped_count       = drops;
        r.underrun_count      = underruns;
        r.short_request_count = shorts;
        r.batch_peak          = held_peak[SAMPLE_W-1:0];
        r.batch_nonzero       = held_nz[SAMPLE_W-1:0];
        return r;
    endfunction

    // Prints one line per mismatch and counts every one of them.
    task automatic report_mismatch(string what);
        mismatches++;
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic check_field(string field, logic [31:0] seen, logic [31:0] want);
        if (seen !== want)
            report_mismatch($sformatf("%s is %0h, should be %0h", field, seen, want));
    endtask

    // Mostly short pauses, now and then a long one.
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(12, 40);
    endfunction

    // A random sample that lands on the extremes and near zero far more often than chance.
    function automatic int rand_sample();
        logic signed [SAMPLE_W-1:0] s;
        int pick;
        s    = SAMPLE_W'($urandom());
        pick = $urandom_range(0, 9);
        if (pick == 0) s = SAMPLE_MAX;
        else if (pick == 1) s = SAMPLE_MIN;
        else if (pick < 4) s = SAMPLE_W'($urandom_range(0, 16) - 8);
        return int'(s);
    endfunction

    task automatic add_item(logic op, int pl, int pr, int fmm, int fmr, logic last);
        mix_item_t it;
        it.op            = op;
        it.psg_left      = SAMPLE_W'(pl);
        it.psg_right     = SAMPLE_W'(pr);
        it.fm_melody     = SAMPLE_W'(fmm);
        it.fm_rhythm     = SAMPLE_W'(fmr);
        it.last_of_batch = last;
        pending_words.push_back(it);
    endtask

    task automatic add_random_item(logic op, logic last);
        add_item(op, rand_sample(), rand_sample(), rand_sample(), rand_sample(), last);
    endtask

    // Random traffic made mostly of complete render batches and pull requests, with
    // some loose words of random kind in between.
    task automatic add_random(int count);
        int   n;
        int   k;
        int   to_go;
        logic op;
        to_go = count;
        while (to_go > 0) begin
            if ($urandom_range(0, 99) < 85) begin
                n  = $urandom_range(1, 8);
                op = $urandom_range(0, 1) ? OP_PULL : OP_PUSH;
                for (k = 0; k < n; k++) add_random_item(op, k == n - 1);
            end else begin
                n = 1;
                add_random_item($urandom_range(0, 1) ? OP_PULL : OP_PUSH,
                                1'($urandom_range(0, 1)));
            end
            to_go -= n;
        end
    endtask

    // The block is idle once nothing is queued, offered or owed; the SETTLE wait
    // then covers its internal pipeline.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || offering || expected_mix.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // A write takes effect at the edge after the enable is raised; the block is idle
    // throughout, so our copy can change straight away.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_FM_ENABLE:    fm_on    = val[0];
            CFG_SOUND_ENABLE: sound_on = val[0];
            CFG_MIX_GAIN:     gain     = int'(val);
            default:          ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(bit fm, bit snd, int g);
        write_reg(CFG_FM_ENABLE, CFG_DATA_W'(fm));
        write_reg(CFG_SOUND_ENABLE, CFG_DATA_W'(snd));
        write_reg(CFG_MIX_GAIN, g[CFG_DATA_W-1:0]);
    endtask

    task automatic random_config();
        int g;
        case ($urandom_range(0, 5))
            0:       g = 0;
            1:       g = 1;
            2:       g = 255;
            3:       g = 16;
            default: g = $urandom_range(0, 255);
        endcase
        set_config(1'($urandom_range(0, 1)), $urandom_range(0, 4) != 0, g);
    endtask

    // Cycle counter and watchdog: a run that does not drain in time has failed.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Driver: at each edge it retires an accepted word (predicting its result there and
    // then), and after the chosen gap it offers the next pending word. valid is assigned
    // once per edge, so a word that follows straight on keeps valid high throughout.
    always @(posedge i_clk) begin : driver
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            offering = 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_mix.push_back(predict_mix(on_offer));
                offering = 1'b0;
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_words.size() != 0) begin
                    on_offer = pending_words.pop_front();
                    offering = 1'b1;
                    in_ch.op            <= on_offer.op;
                    in_ch.psg_left      <= on_offer.psg_left;
                    in_ch.psg_right     <= on_offer.psg_right;
                    in_ch.fm_melody     <= on_offer.fm_melody;
                    in_ch.fm_rhythm     <= on_offer.fm_rhythm;
                    in_ch.last_of_batch <= on_offer.last_of_batch;
                    // The gap follows the acceptance of this word; calm stretches send
                    // back to back.
                    if (send_calm > 0) begin
                        send_calm--;
                        send_gap = 0;
                    end else if ($urandom_range(0, 99) < 45) begin
                        send_gap = pick_pause();
                    end else begin
                        send_gap = 0;
                        if ($urandom_range(0, 99) < 2) send_calm = $urandom_range(30, 100);
                    end
                end
            end
            in_ch.valid <= offering;
        end
    end

    // The one long hold-off of the receiver, timed here on its own so that the sender
    // carries on offering words and the block has to stall its input.
    always @(posedge i_clk) begin : hold_timer
        if (!i_rst_n) begin
            hold_count = 0;
            long_hold <= 1'b0;
        end else if (hold_request && hold_count < LONG_HOLD) begin
            hold_count++;
            long_hold <= 1'b1;
        end else begin
            long_hold <= 1'b0;
        end
    end

    // Monitor: each accepted result word is checked field by field against the oldest
    // prediction, and ready is then chosen for the next cycle.
    always @(posedge i_clk) begin : monitor
        mix_result_t want;
        logic        rdy;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_mix.size() == 0) begin
                    report_mismatch("result word arrived with nothing expected");
                end else begin
                    want = expected_mix.pop_front();
                    check_field("out_left", out_ch.out_left, want.out_left);
                    check_field("out_right", out_ch.out_right, want.out_right);
                    check_field("pull_sample", out_ch.pull_sample, want.pull_sample);
                    check_field("pull_hit", out_ch.pull_hit, want.pull_hit);
                    check_field("fill_level", out_ch.fill_level, want.fill_level);
                    check_field("fill_peak", out_ch.fill_peak, want.fill_peak);
                    check_field("dropped_count", out_ch.dropped_count, want.dropped_count);
                    check_field("underrun_count", out_ch.underrun_count,
                                want.underrun_count);
                    check_field("short_request_count", out_ch.short_request_count,
                                want.short_request_count);
                    check_field("batch_peak", out_ch.batch_peak, want.batch_peak);
                    check_field("batch_nonzero", out_ch.batch_nonzero, want.batch_nonzero);
                end
            end
            if (rcv_stall > 0) begin
                rcv_stall--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
                if (rcv_calm > 0) rcv_calm--;
                else if ($urandom_range(0, 99) < 20) rcv_stall = pick_pause();
                else if ($urandom_range(0, 99) < 2) rcv_calm = $urandom_range(40, 120);
            end
            out_ch.ready <= rdy && !long_hold;
        end
    end

    // Stimulus and the end of the run.
    initial begin : stimulus
        int k;
        int phase;
        // Every input of the block is known from time zero.
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = CFG_FM_ENABLE;
        i_cfg_data          = '0;
        in_ch.valid         = 1'b0;
        in_ch.op            = OP_PUSH;
        in_ch.psg_left      = '0;
        in_ch.psg_right     = '0;
        in_ch.fm_melody     = '0;
        in_ch.fm_rhythm     = '0;
        in_ch.last_of_batch = 1'b0;
        out_ch.ready        = 1'b0;
        hold_request        = 1'b0;
        // Our copy starts where the block does after reset.
        fm_on    = FM_ENABLE_RST;
        sound_on = SOUND_ENABLE_RST;
        gain     = MIX_GAIN_RST;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();

        // Default settings: a pull from the empty ring, the extremes of every input,
        // a pull straight after the push whose sample it reads, a zero mono sample, the
        // FM average truncating toward zero and then draining the ring past empty.
        set_config(1, 1, 16);
        add_item(OP_PULL, 0, 0, 0, 0, 1);
        add_item(OP_PUSH, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, 0);
        add_item(OP_PULL, 0, 0, 0, 0, 0);
        add_item(OP_PUSH, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 0);
        add_item(OP_PUSH, 0, 0, 0, 0, 0);
        add_item(OP_PUSH, 1, 0, -1, 0, 1);
        for (k = 0; k < 3; k++) add_item(OP_PULL, 0, 0, 0, 0, 0);
        add_item(OP_PULL, 0, 0, 0, 0, 1);
        wait_idle();

        // FM off at unit gain: the FM streams must be ignored, and the mono average of
        // a negative odd sum truncates toward zero. Pushes and pulls interleave.
        set_config(0, 1, 1);
        add_item(OP_PUSH, 1, -2, SAMPLE_MAX, SAMPLE_MAX, 0);
        add_item(OP_PUSH, -1, -2, SAMPLE_MIN, 5, 1);
        add_item(OP_PULL, 0, 0, 0, 0, 0);
        add_item(OP_PUSH, SAMPLE_MAX, SAMPLE_MAX, 0, 0, 1);
        wait_idle();

        // Largest gain with sound off: both sides clip, and pulls from a ring that holds
        // samples must still miss and close a short request. The unused index is
        // written too and must change nothing.
        set_config(1, 0, 255);
        write_reg(CFG_UNUSED, 8'hFF);
        add_item(OP_PUSH, 3, -3, SAMPLE_MIN, SAMPLE_MAX, 0);
        add_item(OP_PUSH, 200, -200, 1, 2, 1);
        add_item(OP_PULL, 0, 0, 0, 0, 0);
        add_item(OP_PULL, 0, 0, 0, 0, 1);
        wait_idle();

        // Zero gain silences every push; the held samples are then read back.
        set_config(1, 1, 0);
        add_item(OP_PUSH, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 1);
        add_item(OP_PULL, 0, 0, 0, 0, 0);
        add_item(OP_PULL, 0, 0, 0, 0, 0);
        add_item(OP_PULL, 0, 0, 0, 0, 1);
        wait_idle();

        // Mixed traffic with the receiver holding off for a long stretch at the start, so
        // that the block fills up and stalls its input while words keep being offered.
        set_config(1, 1, 16);
        hold_request <= 1'b1;
        add_random(300);
        wait_idle();

        // Random traffic under a handful of random settings.
        for (phase = 0; phase < 4; phase++) begin
            random_config();
            add_random(220);
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
